/* rtl/bidr_pkg.sv */
package bidr_pkg;

  // Default sizes of the banked RAM and the parameter store
  localparam int RAM_BANKS_DEF   = 16;
  localparam int PARAM_BYTES_DEF = 256;

  // Fixed bank size: the bus offset is nine bits wide
  localparam int BANK_BYTES = 512;
  localparam int OFFSET_W   = 9;

  // Bus decode
  localparam logic [9:0] BANK_ADDR = 10'h3FF;
  localparam int         RAM_SEL_BIT = 9;

  // Bit positions
  localparam int KEY_AVAIL_BIT = 7;
  localparam int KEY_IE_BIT    = 7;
  localparam int SER_IE_BIT    = 7;
  localparam int TARGET_LO     = 4;
  localparam int TARGET_HI     = 5;

  typedef enum logic [2:0] {
    CMD_READ      = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_KEY       = 3'd2,
    CMD_MOUSE     = 3'd3,
    CMD_JOYSTICK  = 3'd4,
    CMD_SERIAL_RX = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    REG_SER_DATA    = 4'h0,
    REG_SER_STATUS  = 4'h1,
    REG_KEY         = 4'h2,
    REG_MOUSE_X     = 4'h3,
    REG_MOUSE_Y     = 4'h4,
    REG_MOUSE_WHEEL = 4'h5,
    REG_MOUSE_BTN   = 4'h6,
    REG_PAD         = 4'h7,
    REG_PARAM_DATA  = 4'hE,
    REG_PARAM_PTR   = 4'hF
  } reg_idx_t;

  // Where the returned byte of a word comes from
  typedef enum logic [1:0] {
    SRC_REG   = 2'd0,
    SRC_RAM   = 2'd1,
    SRC_PARAM = 2'd2
  } rd_src_t;

endpackage

/* rtl/bidr_bank_ram.sv */
module bidr_bank_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          re,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata,
  output logic          busy
);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic          clearing;

  // Sweep zeros through every entry after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'h00;
    end else if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

  assign busy = clearing;

endmodule

/* rtl/banked_io_register_device_unit.sv */
// Path: an accepted word passes the input register, then the result register, which raises
//   out_valid; the RAM and parameter reads land in the result stage.
// Throughput: one word per cycle unless out_ready stalls; state updates commit as a word
//   leaves the input register. Reset: rst (synchronous) clears the valid flags, device state
//   and parameter-store valid bits at once, then the bank RAM is zeroed one byte a cycle
//   across all RAM_BANKS * 512 bytes (8192 at defaults), during which in_ready stays low.
module banked_io_register_device_unit #(
  parameter int RAM_BANKS   = bidr_pkg::RAM_BANKS_DEF,
  parameter int PARAM_BYTES = bidr_pkg::PARAM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [9:0]  address,
  input  logic [7:0]  data,
  input  logic [7:0]  mouse_x,
  input  logic [7:0]  mouse_y,
  input  logic [7:0]  mouse_wheel,
  input  logic [15:0] joystick_buttons,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        rx_accepted,
  output logic        irq
);

  import bidr_pkg::*;

  localparam int BANK_W    = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
  localparam int RAM_AW    = BANK_W + OFFSET_W;
  localparam int RAM_DEPTH = RAM_BANKS * BANK_BYTES;
  localparam int P_AW      = $clog2(PARAM_BYTES);

  // ---------------------------------------------------------------------------
  // Modulo tables: bank_select mod RAM_BANKS and param_pointer mod PARAM_BYTES.
  // Every entry is a constant worked out at elaboration.
  // ---------------------------------------------------------------------------
  logic [BANK_W-1:0] bank_mod  [16];
  logic [P_AW-1:0]   param_mod [256];

  for (genvar gi = 0; gi < 16; gi++) begin : g_bank_mod
    assign bank_mod[gi] = BANK_W'(gi % RAM_BANKS);
  end

  for (genvar gj = 0; gj < 256; gj++) begin : g_param_mod
    assign param_mod[gj] = P_AW'(gj % PARAM_BYTES);
  end

  // ---------------------------------------------------------------------------
  // Device state
  // ---------------------------------------------------------------------------
  logic [3:0] bank_select, bank_select_next;
  logic [7:0] serial_byte, serial_byte_next;
  logic [7:0] serial_ctrl, serial_ctrl_next;
  logic       rx_available, rx_available_next;
  logic [7:0] key_ctrl, key_ctrl_next;
  logic [7:0] key_byte, key_byte_next;
  logic [7:0] mouse_regs [4];
  logic [7:0] mouse_regs_next [4];
  logic [7:0] pad_byte, pad_byte_next;
  logic [7:0] param_pointer, param_pointer_next;

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic        s1_valid;
  logic [2:0]  s1_cmd;
  logic [9:0]  s1_address;
  logic [7:0]  s1_data;
  logic [7:0]  s1_mouse_x;
  logic [7:0]  s1_mouse_y;
  logic [7:0]  s1_mouse_wheel;
  logic [15:0] s1_pad;

  // Result register
  logic        o_valid;
  rd_src_t     o_src;
  logic [7:0]  o_rd;
  logic        o_tx_valid;
  logic [7:0]  o_tx_byte;
  logic        o_rx;
  logic        o_irq;

  logic s1_fire;
  logic in_fire;
  logic ram_busy;

  // Advance the input word when the result register is empty or being drained;
  // take a new word when the RAM is not clearing and the input register is empty or advancing.
  assign s1_fire  = s1_valid && (!o_valid || out_ready);
  assign in_ready = !ram_busy && (!s1_valid || s1_fire);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd         <= cmd;
      s1_address     <= address;
      s1_data        <= data;
      s1_mouse_x     <= mouse_x;
      s1_mouse_y     <= mouse_y;
      s1_mouse_wheel <= mouse_wheel;
      s1_pad         <= joystick_buttons;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode and state update for the word in the input register
  // ---------------------------------------------------------------------------
  logic         is_ram;
  logic         target_serial;
  logic [7:0]   rd_reg;
  rd_src_t      rd_src;
  logic         tx_valid_c;
  logic [7:0]   tx_byte_c;
  logic         rx_acc_c;
  logic         ram_re, ram_we;
  logic         param_re, param_we;
  logic [RAM_AW-1:0] ram_addr;
  logic [P_AW-1:0]   param_idx;
  logic         irq_c;

  assign is_ram        = s1_address[RAM_SEL_BIT];
  assign target_serial = (serial_ctrl[TARGET_HI:TARGET_LO] == 2'b00);
  assign param_idx     = param_mod[param_pointer];

  always_comb begin
    bank_select_next   = bank_select;
    serial_byte_next   = serial_byte;
    serial_ctrl_next   = serial_ctrl;
    rx_available_next  = rx_available;
    key_ctrl_next      = key_ctrl;
    key_byte_next      = key_byte;
    mouse_regs_next    = mouse_regs;
    pad_byte_next      = pad_byte;
    param_pointer_next = param_pointer;
    rd_reg             = 8'h00;
    rd_src             = SRC_REG;
    tx_valid_c         = 1'b0;
    tx_byte_c          = 8'h00;
    rx_acc_c           = 1'b0;
    ram_re             = 1'b0;
    ram_we             = 1'b0;
    param_re           = 1'b0;
    param_we           = 1'b0;

    unique case (cmd_t'(s1_cmd))
      CMD_READ: begin
        if (is_ram) begin
          ram_re = 1'b1;
          rd_src = SRC_RAM;
        end else begin
          unique case (reg_idx_t'(s1_address[3:0]))
            REG_SER_DATA: begin
              // Reading the data byte empties the receiver
              rd_reg            = serial_byte;
              rx_available_next = 1'b0;
            end
            REG_SER_STATUS:  rd_reg = {4'b0000, rx_available, 3'b000};
            REG_KEY: begin
              // Drop key-available once the byte has been read
              rd_reg                       = key_byte;
              key_byte_next[KEY_AVAIL_BIT] = 1'b0;
            end
            REG_MOUSE_X:     rd_reg = mouse_regs[0];
            REG_MOUSE_Y:     rd_reg = mouse_regs[1];
            REG_MOUSE_WHEEL: rd_reg = mouse_regs[2];
            REG_MOUSE_BTN:   rd_reg = mouse_regs[3];
            REG_PAD:         rd_reg = pad_byte;
            REG_PARAM_DATA: begin
              param_re = 1'b1;
              rd_src   = SRC_PARAM;
            end
            REG_PARAM_PTR:   rd_reg = param_pointer;
            default:         rd_reg = 8'h00;  // clock registers read as zero
          endcase
        end
      end
      CMD_WRITE: begin
        if (is_ram) begin
          // The bank register write switches bank first, then stores into the new bank
          if (s1_address == BANK_ADDR) begin
            bank_select_next = s1_data[3:0];
          end
          ram_we = 1'b1;
        end else begin
          unique case (reg_idx_t'(s1_address[3:0]))
            REG_SER_DATA: begin
              serial_byte_next = s1_data;
              if (target_serial) begin
                tx_valid_c = 1'b1;
                tx_byte_c  = s1_data;
              end
            end
            REG_SER_STATUS: serial_ctrl_next   = s1_data;
            REG_KEY:        key_ctrl_next      = s1_data;
            REG_PARAM_DATA: param_we           = 1'b1;
            REG_PARAM_PTR:  param_pointer_next = s1_data;
            default: ;  // read-only and clock registers ignore writes
          endcase
        end
      end
      CMD_KEY: begin
        key_byte_next                = s1_data;
        key_byte_next[KEY_AVAIL_BIT] = 1'b1;
      end
      CMD_MOUSE: begin
        mouse_regs_next[0] = s1_mouse_x;
        mouse_regs_next[1] = s1_mouse_y;
        mouse_regs_next[2] = s1_mouse_wheel;
        mouse_regs_next[3] = s1_data;
      end
      CMD_JOYSTICK: begin
        // Fold the pad mask: high nibble of the low byte, low nibble of the high byte
        pad_byte_next = {s1_pad[7:4], s1_pad[11:8]};
      end
      CMD_SERIAL_RX: begin
        // Latch only with serial target and an empty receiver; else the sender retries
        if (target_serial && !rx_available) begin
          serial_byte_next  = s1_data;
          rx_available_next = 1'b1;
          rx_acc_c          = 1'b1;
        end
      end
      default: ;  // unused codes do nothing
    endcase

    irq_c = (key_ctrl_next[KEY_IE_BIT] && key_byte_next[KEY_AVAIL_BIT])
         || (serial_ctrl_next[SER_IE_BIT] && rx_available_next);
  end

  // RAM address uses the bank as it stands after this word
  assign ram_addr = {bank_mod[bank_select_next], s1_address[OFFSET_W-1:0]};

  // ---------------------------------------------------------------------------
  // Banked RAM with its post-reset clearing sweep
  // ---------------------------------------------------------------------------
  logic [7:0] ram_q;

  bidr_bank_ram #(
    .DEPTH (RAM_DEPTH),
    .AW    (RAM_AW)
  ) u_bank_ram (
    .clk   (clk),
    .rst   (rst),
    .re    (ram_re && s1_fire),
    .we    (ram_we && s1_fire),
    .addr  (ram_addr),
    .wdata (s1_data),
    .rdata (ram_q),
    .busy  (ram_busy)
  );

  // ---------------------------------------------------------------------------
  // Parameter store: an entry never written since reset reads as zero
  // ---------------------------------------------------------------------------
  logic [7:0]             param_mem [PARAM_BYTES];
  logic [PARAM_BYTES-1:0] param_vld;
  logic [7:0]             param_q;
  logic                   param_q_vld;

  always_ff @(posedge clk) begin
    if (param_we && s1_fire) begin
      param_mem[param_idx] <= s1_data;
    end
    if (param_re && s1_fire) begin
      param_q     <= param_mem[param_idx];
      param_q_vld <= param_vld[param_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      param_vld <= '0;
    end else if (param_we && s1_fire) begin
      param_vld[param_idx] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Control and device-state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      o_valid       <= 1'b0;
      bank_select   <= '0;
      serial_byte   <= '0;
      serial_ctrl   <= '0;
      rx_available  <= 1'b0;
      key_ctrl      <= '0;
      key_byte      <= '0;
      mouse_regs    <= '{default: '0};
      pad_byte      <= '0;
      param_pointer <= '0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire) begin
        o_valid <= 1'b1;
      end else if (out_ready) begin
        o_valid <= 1'b0;
      end

      // Commit the word's effects as it moves to the result register
      if (s1_fire) begin
        bank_select   <= bank_select_next;
        serial_byte   <= serial_byte_next;
        serial_ctrl   <= serial_ctrl_next;
        rx_available  <= rx_available_next;
        key_ctrl      <= key_ctrl_next;
        key_byte      <= key_byte_next;
        mouse_regs    <= mouse_regs_next;
        pad_byte      <= pad_byte_next;
        param_pointer <= param_pointer_next;
      end
    end
  end

  // Result payload; hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      o_src      <= rd_src;
      o_rd       <= rd_reg;
      o_tx_valid <= tx_valid_c;
      o_tx_byte  <= tx_byte_c;
      o_rx       <= rx_acc_c;
      o_irq      <= irq_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (o_src)
      SRC_RAM:   read_data = ram_q;
      SRC_PARAM: read_data = param_q_vld ? param_q : 8'h00;
      default:   read_data = o_rd;
    endcase
  end

  assign out_valid   = o_valid;
  assign tx_valid    = o_tx_valid;
  assign tx_byte     = o_tx_byte;
  assign rx_accepted = o_rx;
  assign irq         = o_irq;

endmodule
